[hdl/set_assoc_cache_lru_lookup_defines.svh]
// Assertion macros shared by the cache lookup checker.
// No dependencies.
`ifndef SET_ASSOC_CACHE_LRU_LOOKUP_DEFINES_SVH
`define SET_ASSOC_CACHE_LRU_LOOKUP_DEFINES_SVH
// Implication checked at every clock edge outside reset.
`define SACL_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define SACL_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

[hdl/sacl_pkg.sv]
// Shared types and constants for the set-associative cache lookup.
// No dependencies.
package sacl_pkg;
   localparam int MaxWays = 8;
   localparam int MaxSets = 256;
   localparam int WayBits = 3;
   localparam int SetBits = 8;
   localparam int RankBits = 3;
   localparam int TagBits = 32;

   localparam logic [1:0] CsrWays = 2'd0;
   localparam logic [1:0] CsrSetBits = 2'd1;
   localparam logic [1:0] CsrOffBits = 2'd2;

   typedef enum logic [2:0] {
      ST_CLEAR, ST_IDLE, ST_READ, ST_DECIDE, ST_WRITE, ST_RESP
   } state_type;

   typedef struct packed {
      logic clear_en;
      logic load_req;
      logic decide;
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic clear_done;
   } status_type;
endpackage

[hdl/sacl_ctrl.sv]
// Controller state machine for the cache lookup.
// Depends on sacl_pkg.
module sacl_ctrl
   import sacl_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output cmd_type    cmd,
   input  status_type status
);
   state_type state_ff, state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands.
   always_comb begin
      state_in = state_ff;
      cmd = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear_en = 1'b1;
            if (status.clear_done) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load_req = req_valid;
            if (req_valid) state_in = ST_READ;
         end
         ST_READ: state_in = ST_DECIDE;
         ST_DECIDE: begin
            cmd.decide = 1'b1;
            state_in = ST_WRITE;
         end
         ST_WRITE: begin
            cmd.commit = 1'b1;
            state_in = ST_RESP;
         end
         ST_RESP: begin
            rsp_valid = 1'b1;
            if (rsp_ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end
endmodule

[hdl/sacl_datapath.sv]
// Datapath: set memory, tag compare, LRU update and counters.
// Depends on sacl_pkg.
module sacl_datapath
   import sacl_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  cmd_type            cmd,
   output status_type         status,
   input  logic               csr_write,
   input  logic [1:0]         csr_index,
   input  logic [4:0]         csr_data,
   input  logic [31:0]        req_address,
   output logic               rsp_hit,
   output logic [WayBits-1:0] rsp_way_used,
   output logic [SetBits-1:0] rsp_set_used,
   output logic               rsp_evicted,
   output logic [31:0]        rsp_hit_total,
   output logic [31:0]        rsp_miss_total
);
   localparam int RowBits = MaxWays * (1 + RankBits);

   // Per set: tag memory row and valid/rank row.
   logic [TagBits-1:0] tag_mem [MaxSets][MaxWays];
   logic [RowBits-1:0] meta_mem [MaxSets];

   logic [3:0] ways_ff;
   logic [3:0] sbits_ff;
   logic [4:0] obits_ff;
   logic [SetBits-1:0] clr_ff;
   logic [SetBits-1:0] set_ff, set_in;
   logic [TagBits-1:0] tag_ff, tag_in;
   logic [TagBits-1:0] rtag_ff [MaxWays];
   logic [RowBits-1:0] rmeta_ff;
   logic [RowBits-1:0] nmeta_ff, nmeta_in;
   logic hit_ff, hit_in, ev_ff, ev_in;
   logic [WayBits-1:0] way_ff, way_in;
   logic [31:0] hcnt_ff, mcnt_ff;
   logic [3:0] ways_eff;
   logic [3:0] sbits_eff;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         ways_ff <= 4'd1;
         sbits_ff <= 4'd0;
         obits_ff <= 5'd0;
      end else if (csr_write) begin
         case (csr_index)
            CsrWays: ways_ff <= csr_data[3:0];
            CsrSetBits: sbits_ff <= csr_data[3:0];
            CsrOffBits: obits_ff <= csr_data;
            default: ;
         endcase
      end
   end

   assign ways_eff = (ways_ff == 4'd0) ? 4'd1 : (ways_ff > 4'(MaxWays)) ? 4'(MaxWays) : ways_ff;
   assign sbits_eff = (sbits_ff > 4'(SetBits)) ? 4'(SetBits) : sbits_ff;

   // Split the request address into set and tag.
   always_comb begin
      logic [31:0] shifted;
      logic [SetBits-1:0] mask;
      shifted = req_address >> obits_ff;
      mask = SetBits'((9'd1 << sbits_eff) - 9'd1);
      set_in = shifted[SetBits-1:0] & mask;
      tag_in = (6'(obits_ff) + 6'(sbits_eff) > 6'd31) ?
               TagBits'(0) : TagBits'(req_address >> (6'(obits_ff) + 6'(sbits_eff)));
   end

   // Clear sweep counter after reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (cmd.clear_en) begin
         clr_ff <= clr_ff + 1'b1;
      end
   end
   assign status.clear_done = (clr_ff == SetBits'(MaxSets - 1));

   // Latch request, read the set rows.
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         set_ff <= set_in;
         tag_ff <= tag_in;
      end
      rmeta_ff <= meta_mem[set_ff];
      for (int k = 0; k < MaxWays; k++) rtag_ff[k] <= tag_mem[set_ff][k];
   end

   // Hit search, victim choice and rank update.
   always_comb begin
      logic found;
      logic [RankBits-1:0] best, old;
      logic vk;
      logic [RankBits-1:0] rk;
      logic was_valid;
      hit_in = 1'b0;
      ev_in = 1'b0;
      way_in = '0;
      found = 1'b0;
      best = '0;
      for (int k = MaxWays - 1; k >= 0; k--) begin
         if (k < 32'(ways_eff) && rmeta_ff[k*4] && rtag_ff[k] == tag_ff) begin
            hit_in = 1'b1;
            way_in = WayBits'(k);
         end
      end
      if (!hit_in) begin
         for (int k = MaxWays - 1; k >= 0; k--) begin
            if (k < 32'(ways_eff) && !rmeta_ff[k*4]) begin
               found = 1'b1;
               way_in = WayBits'(k);
            end
         end
         if (!found) begin
            ev_in = 1'b1;
            best = rmeta_ff[3:1];
            way_in = '0;
            for (int k = 1; k < MaxWays; k++) begin
               if (k < 32'(ways_eff) && rmeta_ff[k*4+1 +: RankBits] > best) begin
                  best = rmeta_ff[k*4+1 +: RankBits];
                  way_in = WayBits'(k);
               end
            end
         end
      end
      was_valid = hit_in || !found;
      old = rmeta_ff[32'(way_in)*4+1 +: RankBits];
      nmeta_in = rmeta_ff;
      for (int k = 0; k < MaxWays; k++) begin
         vk = rmeta_ff[k*4];
         rk = rmeta_ff[k*4+1 +: RankBits];
         if (k < 32'(ways_eff) && k != 32'(way_in) && vk &&
             (!was_valid || rk < old) && rk < RankBits'(MaxWays - 1)) begin
            nmeta_in[k*4+1 +: RankBits] = rk + 1'b1;
         end
      end
      nmeta_in[32'(way_in)*4 +: 4] = 4'b0001;
   end

   // Result registers and counters.
   always_ff @(posedge clock) begin
      if (reset) begin
         hcnt_ff <= '0;
         mcnt_ff <= '0;
      end else if (cmd.decide) begin
         hit_ff <= hit_in;
         ev_ff <= ev_in;
         way_ff <= way_in;
         nmeta_ff <= nmeta_in;
         if (hit_in) hcnt_ff <= hcnt_ff + 1'b1;
         else mcnt_ff <= mcnt_ff + 1'b1;
      end
   end

   // Memory writes: clear sweep or commit.
   always_ff @(posedge clock) begin
      if (cmd.clear_en) begin
         meta_mem[clr_ff] <= '0;
      end else if (cmd.commit) begin
         meta_mem[set_ff] <= nmeta_ff;
         if (!hit_ff) tag_mem[set_ff][way_ff] <= tag_ff;
      end
   end

   assign rsp_hit = hit_ff;
   assign rsp_way_used = way_ff;
   assign rsp_set_used = set_ff;
   assign rsp_evicted = ev_ff;
   assign rsp_hit_total = hcnt_ff;
   assign rsp_miss_total = mcnt_ff;
endmodule

[hdl/set_assoc_cache_lru_lookup.sv]
// Top level of the set-associative cache lookup with LRU replacement.
// Depends on sacl_pkg, sacl_ctrl and sacl_datapath.
//
// Usage:
//   req channel: one address per transaction (valid/ready).
//   rsp channel: hit, way, set, evicted and running hit/miss totals.
//   csr port: write enable, index (0 ways, 1 set bits, 2 offset bits), data.
// Flow: a request is taken in idle, the set row is read, the decision is
//   made, the row is written back, and finally the response is shown (states
//   IDLE, READ, DECIDE, WRITE, RESP). One transaction is in flight at a time,
//   so no new request is taken until the response is accepted; the
//   read-modify-write of the set row keeps the lookup to one at a time.
// Reset: a clearing pass zeroes the valid and rank rows of every set; no
//   request is accepted until it finishes.
// Stall: while rsp_ready is low the response holds and no request is taken.
module set_assoc_cache_lru_lookup
   import sacl_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [4:0]  csr_data,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_address,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_hit,
   output logic [2:0]  rsp_way_used,
   output logic [7:0]  rsp_set_used,
   output logic        rsp_evicted,
   output logic [31:0] rsp_hit_total,
   output logic [31:0] rsp_miss_total
);
   cmd_type cmd;
   status_type status;

   sacl_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready,
      .cmd, .status
   );

   sacl_datapath u_dp (
      .clock, .reset, .cmd, .status, .csr_write, .csr_index, .csr_data,
      .req_address, .rsp_hit, .rsp_way_used, .rsp_set_used, .rsp_evicted,
      .rsp_hit_total, .rsp_miss_total
   );
endmodule

[hdl/sacl_checker.sv]
// Port-level checker for the cache lookup, bound to the top level.
// Depends on set_assoc_cache_lru_lookup_defines.svh.
`include "set_assoc_cache_lru_lookup_defines.svh"
module sacl_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_hit,
   input logic        rsp_evicted,
   input logic [31:0] rsp_hit_total,
   input logic [31:0] rsp_miss_total
);
   // A hit never reports an eviction.
   `SACL_ASSERT_IMP(a_hit_no_evict, clock, reset, rsp_valid && rsp_hit, !rsp_evicted)
   // One transaction at a time.
   `SACL_ASSERT_IMP(a_one_inflight, clock, reset, rsp_valid, !req_ready)
   // A stalled response stays valid and keeps its totals.
   `SACL_ASSERT_NXT(a_stall_hold, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_hit_total) && $stable(rsp_miss_total))
   // An accepted request is answered after the pipeline steps.
   `SACL_ASSERT_IMP(a_latency, clock, reset, req_valid && req_ready, ##4 rsp_valid)
endmodule

bind set_assoc_cache_lru_lookup sacl_checker u_checker (.*);
